// ===== hw/rtl/ili_pkg.sv =====
// Shared constants, types and helper functions for the indexed list block.
package ili_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W = 32;
    localparam int POS_W = 8;
    localparam int CMD_W = 3;
    localparam int STAT_W = 2;
    localparam int LEN_W = 7;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [CMD_W-1:0] cmd_t;
    typedef logic [STAT_W-1:0] stat_t;

    localparam cmd_t CMD_GET = 3'd0;
    localparam cmd_t CMD_ADD_HEAD = 3'd1;
    localparam cmd_t CMD_ADD_TAIL = 3'd2;
    localparam cmd_t CMD_ADD_INDEX = 3'd3;
    localparam cmd_t CMD_DELETE = 3'd4;

    localparam stat_t ST_OK = 2'd0;
    localparam stat_t ST_RANGE = 2'd1;
    localparam stat_t ST_FULL = 2'd2;

    typedef logic [1:0] op_t;
    localparam op_t OP_HOLD = 2'd0;
    localparam op_t OP_INSERT = 2'd1;
    localparam op_t OP_DELETE = 2'd2;

    typedef struct packed {
        op_t   op;
        pos_t  pos;
        data_t value;
    } ili_ctrl_t;

    localparam data_t NOT_FOUND = -32'sd1;

    function automatic pos_t cnt_to_pos(input cnt_t c);
        logic [POS_W+CNT_W-1:0] tmp;
        begin
            tmp = {{POS_W{1'b0}}, c};
            return tmp[POS_W-1:0];
        end
    endfunction

    function automatic len_t cnt_to_len(input cnt_t c);
        logic [LEN_W+CNT_W-1:0] tmp;
        begin
            tmp = {{LEN_W{1'b0}}, c};
            return tmp[LEN_W-1:0];
        end
    endfunction

endpackage

// ===== hw/rtl/ili_cell.sv =====
// One list cell: holds one element and shifts, loads or holds each cycle.
module ili_cell
    import ili_pkg::*;
(
    input  logic      clk,
    input  pos_t      idx,
    input  ili_ctrl_t ctrl,
    input  data_t     left_data,
    input  data_t     right_data,
    output data_t     data,
    output data_t     rd_data
);

    data_t data_reg;
    data_t data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            OP_INSERT:
            begin
                if (idx > ctrl.pos)
                begin
                    data_next = left_data;
                end
                else if (idx == ctrl.pos)
                begin
                    data_next = ctrl.value;
                end
            end
            OP_DELETE:
            begin
                if (idx >= ctrl.pos)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign rd_data = (idx == ctrl.pos) ? data_reg : '0;

endmodule

// ===== hw/rtl/indexed_list_insert_delete.sv =====
// Top level of the indexed list with positional insert and delete.
// A result word appears in the cycle after its command word is accepted.
// Throughput: one command per cycle while the result is not stalled; every cell shifts or holds in parallel.
// A stalled result holds the input side only until the result word is taken.
// Reset clears the element count and the result valid flag.
// Element contents are not cleared; only positions below the count are read.
module indexed_list_insert_delete
    import ili_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  cmd_t  cmd,
    input  pos_t  position,
    input  data_t item_value,
    output logic  out_valid,
    input  logic  out_ready,
    output data_t read_value,
    output stat_t status,
    output len_t  length
);

    cnt_t      count_reg;
    cnt_t      count_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    data_t     read_value_reg;
    stat_t     status_reg;
    len_t      length_reg;

    logic      accept;
    ili_ctrl_t ctrl;
    data_t     rv_c;
    stat_t     st_c;
    data_t     rd_or;
    pos_t      cnt_pos;
    pos_t      ins_pos;
    logic      do_insert;
    logic      ins_ok;

    data_t     cell_data [CAPACITY];
    data_t     cell_rd [CAPACITY];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept = in_valid && in_ready;
    assign cnt_pos = cnt_to_pos(count_reg);

    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    always_comb
    begin
        ctrl.op = OP_HOLD;
        ctrl.pos = position;
        ctrl.value = item_value;
        rv_c = '0;
        st_c = ST_OK;
        count_next = count_reg;
        do_insert = 1'b0;
        ins_pos = position;
        unique case (cmd)
            CMD_GET:
            begin
                if (position < cnt_pos)
                begin
                    rv_c = rd_or;
                end
                else
                begin
                    rv_c = NOT_FOUND;
                    st_c = ST_RANGE;
                end
            end
            CMD_ADD_HEAD:
            begin
                do_insert = 1'b1;
                ins_pos = '0;
            end
            CMD_ADD_TAIL:
            begin
                do_insert = 1'b1;
                ins_pos = cnt_pos;
            end
            CMD_ADD_INDEX:
            begin
                do_insert = 1'b1;
                ins_pos = position;
            end
            CMD_DELETE:
            begin
                if (position < cnt_pos)
                begin
                    ctrl.op = accept ? OP_DELETE : OP_HOLD;
                    count_next = count_reg - cnt_t'(1);
                end
                else
                begin
                    st_c = ST_RANGE;
                end
            end
            default:
            begin
                st_c = ST_OK;
            end
        endcase
        if (do_insert)
        begin
            ctrl.pos = ins_pos;
            if (ins_pos > cnt_pos)
            begin
                st_c = ST_RANGE;
            end
            else if (count_reg >= cnt_t'(CAPACITY))
            begin
                st_c = ST_FULL;
            end
            else
            begin
                ctrl.op = accept ? OP_INSERT : OP_HOLD;
                count_next = count_reg + cnt_t'(1);
            end
        end
    end

    assign ins_ok = do_insert && (st_c == ST_OK);

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        data_t left_d;
        data_t right_d;
        if (g == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[g+1];
        end
        ili_cell u_cell (
            .clk        (clk),
            .idx        (pos_t'(g)),
            .ctrl       (ctrl),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[g]),
            .rd_data    (cell_rd[g])
        );
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg <= rv_c;
            status_reg <= st_c;
            length_reg <= cnt_to_len(count_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign read_value = read_value_reg;
    assign status = status_reg;
    assign length = length_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(CAPACITY))
        else $error("element count exceeds capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ins_ok |=> count_reg == $past(count_reg) + cnt_t'(1))
        else $error("accepted insert did not grow the list");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (st_c == ST_FULL) |=> count_reg == cnt_t'(CAPACITY))
        else $error("full status with room left");

    a_length_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> length_reg == cnt_to_len(count_reg))
        else $error("reported length differs from element count");

endmodule
